FILE: hw/rtl/pwsl_pkg.sv
// ----------------------------------------------------------------------------
// pwsl_pkg: shared types and constants of the punctuation/word/string lexer
// Token layout, token kinds, scan modes and the character codes it tests.
// ----------------------------------------------------------------------------
package pwsl_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;
    // Width of the offset, length and line fields on the ports.
    localparam int FIELD_BITS      = 16;
    // Most tokens that one byte can cause.
    localparam int MAX_TOKENS      = 3;

    typedef enum logic [3:0] {
        KIND_PLUS,
        KIND_MINUS,
        KIND_STAR,
        KIND_SLASH,
        KIND_EQUAL,
        KIND_LPAREN,
        KIND_LBRACE,
        KIND_RPAREN,
        KIND_RBRACE,
        KIND_COMMA,
        KIND_SEMI,
        KIND_COLON,
        KIND_TEXT,
        KIND_END,
        KIND_NONE = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STR,
        MODE_DONE
    } t_mode;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [3:0]            token_kind;
        logic [FIELD_BITS-1:0] token_offset;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] token_line;
        logic                  run_final;
    } t_token;

    typedef t_token [MAX_TOKENS-1:0] t_token_set;

    // Tokens caused by one byte, slot 0 first.
    typedef struct packed {
        logic [1:0] count;
        t_token_set toks;
    } t_group;

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "=":     k = KIND_EQUAL;
            "(":     k = KIND_LPAREN;
            "{":     k = KIND_LBRACE;
            ")":     k = KIND_RPAREN;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            ":":     k = KIND_COLON;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/pwsl_core.sv
// ----------------------------------------------------------------------------
// pwsl_core: lexer state and per-byte token decision
// Holds position, line and the open word or string, and works out in one
// pass the up to three tokens that the registered byte causes.
// ----------------------------------------------------------------------------
module pwsl_core #(
    parameter int OFFSET_BITS = pwsl_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = pwsl_pkg::LINE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_text_byte,
    input  logic             i_is_last,
    output pwsl_pkg::t_group o_group
);

    // Counters never exceed the field width, so they are no wider than it.
    localparam int OW = (OFFSET_BITS < pwsl_pkg::FIELD_BITS) ? OFFSET_BITS
                                                              : pwsl_pkg::FIELD_BITS;
    localparam int LW = (LINE_BITS < pwsl_pkg::FIELD_BITS) ? LINE_BITS
                                                            : pwsl_pkg::FIELD_BITS;

    logic [OW-1:0]   r_pos,   n_pos;
    logic [LW-1:0]   r_line,  n_line;
    pwsl_pkg::t_mode r_mode,  n_mode;
    logic [OW-1:0]   r_poff,  n_poff;
    logic [OW-1:0]   r_plen,  n_plen;
    logic [LW-1:0]   r_pline, n_pline;
    logic            r_esc,   n_esc;

    pwsl_pkg::t_token_set toks;
    logic [1:0]           cnt;
    logic                 is_ws;
    pwsl_pkg::t_kind      pk;

    function automatic logic [OW-1:0] inc_off(input logic [OW-1:0] v);
        return (v == '1) ? v : v + OW'(1);
    endfunction

    function automatic logic [LW-1:0] inc_line(input logic [LW-1:0] v);
        return (v == '1) ? v : v + LW'(1);
    endfunction

    function automatic pwsl_pkg::t_token mk(input logic [3:0] k, input logic [OW-1:0] off,
                                           input logic [OW-1:0] len,
                                           input logic [LW-1:0] ln);
        pwsl_pkg::t_token t;
        t.token_kind   = k;
        t.token_offset = pwsl_pkg::FIELD_BITS'(off);
        t.token_length = pwsl_pkg::FIELD_BITS'(len);
        t.token_line   = pwsl_pkg::FIELD_BITS'(ln);
        t.run_final    = 1'b0;
        return t;
    endfunction

    function automatic pwsl_pkg::t_token_set push(input pwsl_pkg::t_token_set arr,
                                                  input logic [1:0] c,
                                                  input pwsl_pkg::t_token t);
        pwsl_pkg::t_token_set a;
        a = arr;
        if (c != 2'd3) begin
            a[c] = t;
        end
        return a;
    endfunction

    always_comb begin
        is_ws = i_text_byte inside {pwsl_pkg::CH_SPACE, pwsl_pkg::CH_TAB, pwsl_pkg::CH_NL};
        pk    = pwsl_pkg::punct_kind(i_text_byte);
    end

    // The body follows the order of events within one byte: the byte itself,
    // then the end of text when it is marked last.
    always_comb begin
        n_pos   = r_pos;
        n_line  = r_line;
        n_mode  = r_mode;
        n_poff  = r_poff;
        n_plen  = r_plen;
        n_pline = r_pline;
        n_esc   = r_esc;
        toks    = '0;
        cnt     = 2'd0;

        if (r_mode != pwsl_pkg::MODE_DONE) begin
            if (i_text_byte != pwsl_pkg::CH_NUL) begin
                if (n_mode == pwsl_pkg::MODE_STR) begin
                    n_plen = inc_off(n_plen);
                    if (i_text_byte == pwsl_pkg::CH_NL) begin
                        n_line = inc_line(n_line);
                    end
                    if (i_text_byte == pwsl_pkg::CH_QUOTE && !n_esc) begin
                        toks   = push(toks, cnt, mk(pwsl_pkg::KIND_TEXT, n_poff, n_plen,
                                                    n_pline));
                        cnt    = cnt + 2'd1;
                        n_mode = pwsl_pkg::MODE_IDLE;
                    end
                    n_esc = (i_text_byte == pwsl_pkg::CH_BSLASH);
                end else if (is_ws || pk != pwsl_pkg::KIND_NONE
                             || i_text_byte == pwsl_pkg::CH_QUOTE) begin
                    // A separator, a mark or an opening quote closes any open word.
                    if (n_mode == pwsl_pkg::MODE_WORD) begin
                        toks = push(toks, cnt, mk(pwsl_pkg::KIND_TEXT, n_poff, n_plen,
                                                  n_pline));
                        cnt  = cnt + 2'd1;
                    end
                    n_mode = pwsl_pkg::MODE_IDLE;
                    if (is_ws) begin
                        if (i_text_byte == pwsl_pkg::CH_NL) begin
                            n_line = inc_line(n_line);
                        end
                    end else if (pk != pwsl_pkg::KIND_NONE) begin
                        toks = push(toks, cnt, mk(pk, n_pos, OW'(1), n_line));
                        cnt  = cnt + 2'd1;
                    end else begin
                        n_mode  = pwsl_pkg::MODE_STR;
                        n_poff  = n_pos;
                        n_plen  = OW'(1);
                        n_pline = n_line;
                        n_esc   = 1'b0;
                    end
                end else if (n_mode == pwsl_pkg::MODE_WORD) begin
                    n_plen = inc_off(n_plen);
                end else begin
                    n_mode  = pwsl_pkg::MODE_WORD;
                    n_poff  = n_pos;
                    n_plen  = OW'(1);
                    n_pline = n_line;
                    n_esc   = 1'b0;
                end
                n_pos = inc_off(n_pos);
            end

            if (i_text_byte == pwsl_pkg::CH_NUL || i_is_last) begin
                if (n_mode == pwsl_pkg::MODE_WORD || n_mode == pwsl_pkg::MODE_STR) begin
                    toks = push(toks, cnt, mk(pwsl_pkg::KIND_TEXT, n_poff, n_plen, n_pline));
                    cnt  = cnt + 2'd1;
                end
                toks   = push(toks, cnt, mk(pwsl_pkg::KIND_END, n_pos, OW'(0), n_line));
                cnt    = cnt + 2'd1;
                n_mode = pwsl_pkg::MODE_DONE;
            end
        end

        if (cnt != 2'd0) begin
            toks[cnt - 2'd1].run_final = 1'b1;
        end
    end

    assign o_group.count = cnt;
    assign o_group.toks  = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_line  <= LW'(1);
            r_mode  <= pwsl_pkg::MODE_IDLE;
            r_poff  <= '0;
            r_plen  <= '0;
            r_pline <= LW'(1);
            r_esc   <= 1'b0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_mode  <= n_mode;
            r_poff  <= n_poff;
            r_plen  <= n_plen;
            r_pline <= n_pline;
            r_esc   <= n_esc;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == pwsl_pkg::MODE_DONE |-> o_group.count == 2'd0)
        else $error("pwsl_core: tokens produced after the end of text");

    a_full_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_group.count == 2'd3 |-> o_group.toks[2].token_kind == pwsl_pkg::KIND_END)
        else $error("pwsl_core: a three-token word does not close with the end token");

    a_nul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_text_byte == pwsl_pkg::CH_NUL |=> r_mode == pwsl_pkg::MODE_DONE)
        else $error("pwsl_core: a NUL byte did not end the text");
`endif

endmodule

FILE: hw/rtl/pwsl_tok_queue.sv
// ----------------------------------------------------------------------------
// pwsl_tok_queue: result register for the tokens of one byte
// Holds up to three tokens; hands out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module pwsl_tok_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pwsl_pkg::t_group i_group,
    output logic             o_space,
    output logic             o_valid,
    output pwsl_pkg::t_token o_token,
    input  logic             i_ready
);

    logic [1:0]           r_cnt;
    pwsl_pkg::t_token_set r_slot;
    logic                 pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    // A new group may load as the last held token leaves.
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_token = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_group.toks;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

`ifndef NO_ASSERTIONS
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("pwsl_tok_queue: group loaded over tokens not yet taken");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> o_token.run_final)
        else $error("pwsl_tok_queue: last token of a group lacks run_final");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token))
        else $error("pwsl_tok_queue: waiting token changed before it was taken");
`endif

endmodule

FILE: hw/rtl/punctuation_word_string_lexer.sv
// ----------------------------------------------------------------------------
// punctuation_word_string_lexer: byte-stream lexer top level
// Input register, lexer core and token result register.
// ----------------------------------------------------------------------------
// Takes one source byte per word and returns tokens with kind, offset, length
// and line. A byte is taken every cycle as long as each byte causes at most
// one token and the consumer keeps up: it passes an input register, is decided
// in one pass by the core and lands in a three-entry result register. A byte
// that causes two or three tokens (a word closed by a mark, or the end of text)
// stalls the next token-making byte, since the result register hands out one
// token per cycle to a ready consumer. Bytes causing no token pass even while
// tokens wait. After the end token all further bytes are taken and dropped.
module punctuation_word_string_lexer #(
    parameter int OFFSET_BITS = pwsl_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = pwsl_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_token_line,
    output logic        o_run_final
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             take;
    logic             space;
    pwsl_pkg::t_group group;
    pwsl_pkg::t_token tok;

    assign take    = r_in_valid && (group.count == 2'd0 || space);
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_is_last;
        end
    end

    pwsl_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_text_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .o_group     (group)
    );

    pwsl_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && group.count != 2'd0),
        .i_group (group),
        .o_space (space),
        .o_valid (o_valid),
        .o_token (tok),
        .i_ready (i_ready)
    );

    assign o_token_kind   = tok.token_kind;
    assign o_token_offset = tok.token_offset;
    assign o_token_length = tok.token_length;
    assign o_token_line   = tok.token_line;
    assign o_run_final    = tok.run_final;

endmodule
